@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every rising edge outside reset
`define SGF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SGF_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SGF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sgf_pkg.sv @@
// shared types and constants of the stretch guide finder
package sgf_pkg;

   localparam int PIXEL_W     = 32;
   localparam int COORD_W     = 9;
   localparam int COORD_MAX   = 511;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;
   localparam int RSP_DATA_W  = 40;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [COORD_W-1:0] coord_type;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ROW    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_HORIZ = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_VERT  = 3'd5;

endpackage

@@ rtl/stretch_guide_finder_unit.sv @@
// stretch guide finder top level: pixel load, guide search and result register
//
//   channel | direction | payload (lowest bit first)                | transfer when
//   req     | in        | tdata: pixel_rgba[31:0]; tlast: last_pixel | req_tvalid & req_tready
//   rsp     | out       | tdata: top, right, bottom, left (9b each)  | rsp_tvalid & rsp_tready
//   csr     | in        | csr_index selects register, csr_wdata      | csr_we
//
// loading takes one pixel per cycle while req_tvalid holds; the transfer flagged by tlast starts the search
// search: every probe is one read of the pixel ram (an address state, then a compare state)
// reset clears control and guides and presets config; pixel ram contents stay undefined, no clear pass
// req_tready is low from the last pixel until the result sits in the output register
// a waiting result does not block loading the next image

`include "assert_macros.svh"

module stretch_guide_finder_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sgf_pkg::PIXEL_W-1:0]      req_tdata,   // pixel_rgba
   input  logic                             req_tlast,   // last_pixel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sgf_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // top_offset, right_offset,
                                                         // bottom_offset, left_offset, pad
   input  logic                             csr_we,
   input  logic [sgf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sgf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import sgf_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam coord_type WCAP = (MAX_WIDTH  > COORD_MAX) ? coord_type'(COORD_MAX)
                                                         : coord_type'(MAX_WIDTH);
   localparam coord_type HCAP = (MAX_HEIGHT > COORD_MAX) ? coord_type'(COORD_MAX)
                                                         : coord_type'(MAX_HEIGHT);
   localparam int PAD_W = RSP_DATA_W - 4 * COORD_W;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SETUP,
      ST_PASS,
      ST_REF_RD,
      ST_REF_CMP,
      ST_BWD_RD,
      ST_BWD_CMP,
      ST_FWD_RD,
      ST_FWD_CMP,
      ST_NEXT,
      ST_DONE
   } state_type;

   // configuration registers
   coord_type       image_width_ff;
   coord_type       image_height_ff;
   logic [7:0]      start_col_ff;
   logic [7:0]      start_row_ff;
   logic            search_h_ff;
   logic            search_v_ff;

   // control and scan state
   state_type       state_ff;
   logic [AW-1:0]   lp_ff;
   logic [AW-1:0]   lp_in;
   logic            vert_ff;      // 0: row pass (left/right), 1: column pass (top/bottom)
   coord_type       w_ff, h_ff, sx_ff, sy_ff;
   coord_type       a_ff;         // outer index: row in row pass, column in column pass
   coord_type       b_ff;         // probe position along the searched axis
   coord_type       lo_ff;        // running backward guide
   coord_type       hi_ff;        // running forward guide
   pixel_type       ref_ff;
   coord_type       left_ff, right_ff, top_ff, bottom_ff;
   logic            rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   // combinational helpers
   coord_type       w_calc, h_calc, sx_calc, sy_calc;
   coord_type       n_sel, m_sel, s_sel;
   logic            en_sel;
   coord_type       row_sel, col_sel;
   logic [17:0]     prod;
   logic [17:0]     lin;
   logic [AW-1:0]   rd_addr;
   pixel_type       rd_data;
   logic            wr_en;
   logic            pix_diff;
   logic            bwd_ok_ref;   // a backward probe exists after the reference read
   logic            bwd_ok_more;  // another backward probe after this one
   logic            fwd_ok_start;
   logic            fwd_ok_more;
   logic            row_more;
   logic            pass_end;
   coord_type       rec_lo, rec_hi;
   logic            rsp_free;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 9'd256;
         image_height_ff <= 9'd256;
         start_col_ff    <= 8'd128;
         start_row_ff    <= 8'd128;
         search_h_ff     <= 1'b1;
         search_v_ff     <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            CSR_START_COL:    start_col_ff    <= csr_wdata[7:0];
            CSR_START_ROW:    start_row_ff    <= csr_wdata[7:0];
            CSR_SEARCH_HORIZ: search_h_ff     <= csr_wdata[0];
            CSR_SEARCH_VERT:  search_v_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- size and start clamping ----------------
   always_comb begin
      w_calc  = (image_width_ff == '0) ? 9'd1
              : ((image_width_ff > WCAP) ? WCAP : image_width_ff);
      h_calc  = (image_height_ff == '0) ? 9'd1
              : ((image_height_ff > HCAP) ? HCAP : image_height_ff);
      sx_calc = ({1'b0, start_col_ff} >= w_calc) ? (w_calc - 9'd1) : {1'b0, start_col_ff};
      sy_calc = ({1'b0, start_row_ff} >= h_calc) ? (h_calc - 9'd1) : {1'b0, start_row_ff};
   end

   // ---------------- per-pass selection ----------------
   // row pass: outer over rows, probes along columns; column pass swaps the two
   assign n_sel   = vert_ff ? h_ff : w_ff;
   assign m_sel   = vert_ff ? w_ff : h_ff;
   assign s_sel   = vert_ff ? sy_ff : sx_ff;
   assign en_sel  = vert_ff ? search_v_ff : search_h_ff;
   assign row_sel = vert_ff ? b_ff : a_ff;
   assign col_sel = vert_ff ? a_ff : b_ff;

   // raster address; always below w * h so it stays inside the store
   assign prod    = row_sel * w_ff;
   assign lin     = prod + 18'(col_sel);
   assign rd_addr = AW'(lin);

   assign pix_diff     = (rd_data != ref_ff);
   assign bwd_ok_ref   = {1'b0, s_sel} > ({1'b0, lo_ff} + 10'd1);
   assign bwd_ok_more  = {1'b0, b_ff}  > ({1'b0, lo_ff} + 10'd1);
   assign fwd_ok_start = ({1'b0, s_sel} + 10'd1) < {1'b0, hi_ff};
   assign fwd_ok_more  = ({1'b0, b_ff}  + 10'd1) < {1'b0, hi_ff};
   assign row_more     = ({1'b0, a_ff}  + 10'd1) < {1'b0, m_sel};

   // end of a pass: disabled axis takes the start point; searched axis takes lo + 1 and hi
   assign pass_end = ((state_ff == ST_PASS) && !en_sel)
                  || ((state_ff == ST_NEXT) && !row_more);
   assign rec_lo   = (state_ff == ST_PASS) ? s_sel : (lo_ff + 9'd1);
   assign rec_hi   = (state_ff == ST_PASS) ? s_sel : hi_ff;

   // ---------------- load side ----------------
   assign req_tready = (state_ff == ST_LOAD);
   assign wr_en      = req_tvalid && req_tready;
   assign lp_in      = req_tlast ? '0
                     : ((lp_ff == AW'(DEPTH - 1)) ? '0 : (lp_ff + 1'b1));

   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         lp_ff         <= '0;
         vert_ff       <= 1'b0;
         left_ff       <= '0;
         right_ff      <= '0;
         top_ff        <= '0;
         bottom_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // in the done state the new result takes the register over
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_tvalid) begin
                  lp_ff <= lp_in;
                  if (req_tlast) begin
                     state_ff <= ST_SETUP;
                  end
               end
            end
            ST_SETUP: begin
               w_ff     <= w_calc;
               h_ff     <= h_calc;
               sx_ff    <= sx_calc;
               sy_ff    <= sy_calc;
               vert_ff  <= 1'b0;
               state_ff <= ST_PASS;
            end
            ST_PASS: begin
               if (en_sel) begin
                  lo_ff    <= '0;
                  hi_ff    <= n_sel;
                  a_ff     <= '0;
                  b_ff     <= s_sel;
                  state_ff <= ST_REF_RD;
               end
            end
            ST_REF_RD: state_ff <= ST_REF_CMP;
            ST_REF_CMP: begin
               ref_ff <= rd_data;
               if (bwd_ok_ref) begin
                  b_ff     <= s_sel - 9'd1;
                  state_ff <= ST_BWD_RD;
               end else begin
                  // the start point itself always matches, so forward probes begin after it
                  b_ff     <= s_sel + 9'd1;
                  state_ff <= fwd_ok_start ? ST_FWD_RD : ST_NEXT;
               end
            end
            ST_BWD_RD: state_ff <= ST_BWD_CMP;
            ST_BWD_CMP: begin
               if (pix_diff) begin
                  lo_ff    <= b_ff;
                  b_ff     <= s_sel + 9'd1;
                  state_ff <= fwd_ok_start ? ST_FWD_RD : ST_NEXT;
               end else if (bwd_ok_more) begin
                  b_ff     <= b_ff - 9'd1;
                  state_ff <= ST_BWD_RD;
               end else begin
                  b_ff     <= s_sel + 9'd1;
                  state_ff <= fwd_ok_start ? ST_FWD_RD : ST_NEXT;
               end
            end
            ST_FWD_RD: state_ff <= ST_FWD_CMP;
            ST_FWD_CMP: begin
               if (pix_diff) begin
                  hi_ff    <= b_ff;
                  state_ff <= ST_NEXT;
               end else if (fwd_ok_more) begin
                  b_ff     <= b_ff + 9'd1;
                  state_ff <= ST_FWD_RD;
               end else begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (row_more) begin
                  a_ff     <= a_ff + 9'd1;
                  b_ff     <= s_sel;
                  state_ff <= ST_REF_RD;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {{PAD_W{1'b0}}, left_ff, h_ff - bottom_ff,
                                    w_ff - right_ff, top_ff};
                  state_ff      <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
         // record the guides of a finished pass and move on
         if (pass_end) begin
            if (!vert_ff) begin
               left_ff  <= rec_lo;
               right_ff <= rec_hi;
               vert_ff  <= 1'b1;
               state_ff <= ST_PASS;
            end else begin
               top_ff    <= rec_lo;
               bottom_ff <= rec_hi;
               state_ff  <= ST_DONE;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------- pixel store ----------------
   sgf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_pixel_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lp_ff),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- assertions ----------------
   `SGF_ASSERT_IMPL(a_bwd_window, clock, reset, state_ff == ST_BWD_CMP, (b_ff < s_sel) && (b_ff > lo_ff), "backward probe outside search window")
   `SGF_ASSERT_IMPL(a_fwd_window, clock, reset, state_ff == ST_FWD_CMP, (b_ff > s_sel) && (b_ff < hi_ff), "forward probe outside search window")
   `SGF_ASSERT_NEXT(a_result_out, clock, reset, (state_ff == ST_DONE) && rsp_free, rsp_tvalid_ff && (state_ff == ST_LOAD), "finished search did not present a result")
   `SGF_ASSERT(a_no_load_busy, clock, reset, !req_tready || (state_ff == ST_LOAD), "pixel accepted while searching")

endmodule

@@ rtl/sgf_ram.sv @@
// generic simple dual-port ram with registered read
module sgf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/sgf_checker.sv @@
`timescale 1ns / 100ps
// checker for the stretch guide finder: predicts guide offsets per image and compares results
module sgf_checker
   import sgf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // pixel_rgba
   input  logic                   req_tlast,   // last_pixel
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // top, right, bottom, left offsets, zero pad
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     expect_count,
   output int                     error_count
);

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   // lowest field in the lowest bits, as on rsp_tdata
   typedef struct packed {
      coord_type left;
      coord_type bottom;
      coord_type right;
      coord_type top;
   } offsets_type;

   pixel_type   pixel_mem [STORE_DEPTH];
   int          load_addr;
   coord_type   width_reg;
   coord_type   height_reg;
   logic [7:0]  start_col_reg;
   logic [7:0]  start_row_reg;
   logic        horiz_reg;
   logic        vert_reg;
   offsets_type predicted_offsets [$];

   function automatic int clamp_size(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic pixel_type pixel_at(int row, int col, int w);
      return pixel_mem[(row * w + col) % STORE_DEPTH];
   endfunction

   // guide search over the stored image with the current settings
   function automatic offsets_type find_offsets();
      int          w, h, sx, sy, a, b;
      int          lead, trail, upper, lower;
      pixel_type   anchor;
      offsets_type o;
      w  = clamp_size(int'(width_reg), MAX_WIDTH);
      h  = clamp_size(int'(height_reg), MAX_HEIGHT);
      sx = (int'(start_col_reg) >= w) ? w - 1 : int'(start_col_reg);
      sy = (int'(start_row_reg) >= h) ? h - 1 : int'(start_row_reg);

      if (horiz_reg) begin
         lead  = 0;
         trail = w;
         for (a = 0; a < h; a++) begin
            anchor = pixel_at(a, sx, w);
            // column 0 is never probed: the scan stops above the current guide
            for (b = sx - 1; b > lead; b--) begin
               if (pixel_at(a, b, w) != anchor) begin
                  lead = b;
                  break;
               end
            end
            for (b = sx; b < trail; b++) begin
               if (pixel_at(a, b, w) != anchor) begin
                  trail = b;
                  break;
               end
            end
         end
         lead++;
      end else begin
         lead  = sx;
         trail = sx;
      end

      if (vert_reg) begin
         upper = 0;
         lower = h;
         for (a = 0; a < w; a++) begin
            anchor = pixel_at(sy, a, w);
            for (b = sy - 1; b > upper; b--) begin
               if (pixel_at(b, a, w) != anchor) begin
                  upper = b;
                  break;
               end
            end
            for (b = sy; b < lower; b++) begin
               if (pixel_at(b, a, w) != anchor) begin
                  lower = b;
                  break;
               end
            end
         end
         upper++;
      end else begin
         upper = sy;
         lower = sy;
      end

      o.top    = coord_type'(upper);
      o.right  = coord_type'(w - trail);
      o.bottom = coord_type'(h - lower);
      o.left   = coord_type'(lead);
      return o;
   endfunction

   function automatic void check_field(string name, coord_type want, coord_type got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      offsets_type want;
      offsets_type got;
      if (reset) begin
         error_count   = 0;
         load_addr     = 0;
         width_reg     = 9'd256;
         height_reg    = 9'd256;
         start_col_reg = 8'd128;
         start_row_reg = 8'd128;
         horiz_reg     = 1'b1;
         vert_reg      = 1'b1;
         predicted_offsets.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg     = csr_wdata;
               CSR_IMAGE_HEIGHT: height_reg    = csr_wdata;
               CSR_START_COL:    start_col_reg = csr_wdata[7:0];
               CSR_START_ROW:    start_row_reg = csr_wdata[7:0];
               CSR_SEARCH_HORIZ: horiz_reg     = csr_wdata[0];
               CSR_SEARCH_VERT:  vert_reg      = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pixel_mem[load_addr] = req_tdata;
            load_addr = (load_addr + 1) % STORE_DEPTH;
            if (req_tlast) begin
               load_addr = 0;
               predicted_offsets.push_back(find_offsets());
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[4*COORD_W-1:0];
            if (predicted_offsets.size() == 0) begin
               error_count++;
               $display("%0t ns: result expected none actual %h", $time, rsp_tdata);
            end else begin
               want = predicted_offsets.pop_front();
               check_field("top_offset", want.top, got.top);
               check_field("right_offset", want.right, got.right);
               check_field("bottom_offset", want.bottom, got.bottom);
               check_field("left_offset", want.left, got.left);
               check_field("pad", '0, coord_type'(rsp_tdata[RSP_DATA_W-1:4*COORD_W]));
            end
         end
      end
      expect_count <= predicted_offsets.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// testbench top for the stretch guide finder: stimulus, stalls and verdict
module tb;
   import sgf_pkg::*;

   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 256;
   localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int RANDOM_ITEMS = 900;
   // first image covers every store entry that a later search may read
   localparam int PREFILL_SIDE = 32;
   localparam int AREA_CAP     = PREFILL_SIDE * PREFILL_SIDE;
   // quiet cycles before touching registers or ending the run
   localparam int IDLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES = 64;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   pixel_type              req_tdata  = '0;   // pixel_rgba
   logic                   req_tlast  = 1'b0; // last_pixel
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // top, right, bottom, left offsets, pad
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int expect_count;
   int error_count;

   // effective image size as the block sees it, used only to plan loads
   int          cols = MAX_WIDTH;
   int          rows = MAX_HEIGHT;
   // image content: pixels are flat within bands, bands split at random cuts
   int unsigned col_band [MAX_WIDTH];
   int unsigned row_band [MAX_HEIGHT];
   pixel_type   tone_base;
   pixel_type   tone_col;
   pixel_type   tone_row;
   int unsigned noise_rate;
   // burst modes: no gaps on that side while set
   bit          steady_send;
   bit          steady_take;
   bit          hurry;
   int          random_items;

   stretch_guide_finder_unit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sgf_checker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .expect_count (expect_count),
      .error_count  (error_count)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int fit_size(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // one pixel transfer; valid stays high into the next transfer when no gap is drawn
   task automatic send_pixel(pixel_type d, logic last);
      int gap;
      gap = (steady_send || hurry) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(0, 63) == 0) steady_send = !steady_send;
   endtask

   // hold the sender until every predicted result has come back, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expect_count != 0);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // registers change only with the block idle; all six go out back to back
   task automatic configure(logic [8:0] w, logic [8:0] h, logic [7:0] sc, logic [7:0] sr,
                            logic hs, logic vs);
      settle();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_START_COL, {1'b0, sc});
      write_reg(CSR_START_ROW, {1'b0, sr});
      write_reg(CSR_SEARCH_HORIZ, {8'd0, hs});
      write_reg(CSR_SEARCH_VERT, {8'd0, vs});
      csr_we <= 1'b0;
      cols = fit_size(int'(w), MAX_WIDTH);
      rows = fit_size(int'(h), MAX_HEIGHT);
   endtask

   function automatic pixel_type pick_tone();
      case ($urandom_range(0, 3))
         0: return '0;                              // flat along this axis
         1: return pixel_type'(1) << $urandom_range(0, 31); // single-bit steps
         default: return $urandom();
      endcase
   endfunction

   task automatic plan_pattern();
      int unsigned col_odds, row_odds;
      col_odds  = $urandom_range(2, 16);
      row_odds  = $urandom_range(2, 16);
      tone_base = $urandom();
      tone_col  = pick_tone();
      tone_row  = pick_tone();
      col_band[0] = 0;
      row_band[0] = 0;
      for (int i = 1; i < MAX_WIDTH; i++)
         col_band[i] = col_band[i-1] + ($urandom_range(1, col_odds) == 1);
      for (int i = 1; i < MAX_HEIGHT; i++)
         row_band[i] = row_band[i-1] + ($urandom_range(1, row_odds) == 1);
      noise_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(16, 256);
   endtask

   function automatic pixel_type pixel_at(int idx);
      int r, c;
      r = idx / cols;
      c = idx % cols;
      return tone_base ^ (col_band[c] * tone_col) ^ (row_band[r % MAX_HEIGHT] * tone_row);
   endfunction

   // raster load of count pixels; anything past the store end gets a distinct color
   task automatic send_image(int count);
      pixel_type d;
      for (int i = 0; i < count; i++) begin
         d = (i >= STORE_DEPTH) ? ~pixel_at(i - STORE_DEPTH) : pixel_at(i);
         if (noise_rate != 0 && $urandom_range(1, noise_rate) == 1)
            d = $urandom_range(0, 1) ? d ^ (pixel_type'(1) << $urandom_range(0, 31))
                                     : pixel_type'($urandom());
         send_pixel(d, i == count - 1);
      end
   endtask

   function automatic logic [8:0] draw_size();
      case ($urandom_range(0, 19))
         0: begin
            // zero, saturation and the edges of the legal range
            case ($urandom_range(0, 5))
               0: return 9'd0;
               1: return 9'd1;
               2: return 9'd255;
               3: return 9'd256;
               4: return 9'd257;
               default: return 9'd511;
            endcase
         end
         1, 2: return 9'($urandom_range(13, 64));
         default: return 9'($urandom_range(1, 10));
      endcase
   endfunction

   function automatic logic [7:0] pick_start(int size);
      case ($urandom_range(0, 7))
         0: return 8'd0;                          // no backward search
         1: return 8'($urandom_range(0, 255));    // often past the edge, gets clamped
         default: return 8'($urandom_range(0, size - 1));
      endcase
   endfunction

   // result side: random stalls per transfer with occasional stall-free stretches
   initial begin
      int gap;
      forever begin
         gap = steady_take ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if ($urandom_range(0, 7) == 0) steady_take = !steady_take;
      end
   end

   // main stimulus
   initial begin
      logic [8:0] w, h;
      int         area, count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // first image fills the low store entries; every later search reads only
      // below the area cap, so it never reaches an unwritten entry
      configure(9'(PREFILL_SIDE), 9'(PREFILL_SIDE), 8'(PREFILL_SIDE / 2),
                8'(PREFILL_SIDE / 2), 1'b1, 1'b1);
      plan_pattern();
      noise_rate = 0;
      hurry = 1'b1;
      send_image(AREA_CAP);
      hurry = 1'b0;

      // directed: single pixel image with start at the origin
      configure(9'd1, 9'd1, 8'd0, 8'd0, 1'b1, 1'b1);
      send_pixel(32'h0000_0000, 1'b1);
      // zero size is taken as one, start far past the edge is clamped
      configure(9'd0, 9'd0, 8'd255, 8'd255, 1'b1, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      // width above the maximum saturates; short load; horizontal only
      configure(9'd511, 9'd2, 8'd255, 8'd0, 1'b1, 1'b0);
      send_pixel(32'h8000_0000, 1'b0);
      send_pixel(32'h0000_0001, 1'b1);
      // height above the maximum; vertical only
      configure(9'd2, 9'd511, 8'd1, 8'd255, 1'b0, 1'b1);
      send_pixel(32'hA5A5_A5A5, 1'b0);
      send_pixel(32'h5A5A_5A5A, 1'b1);
      // both axes off: offsets come straight from the start point
      configure(9'd256, 9'd256, 8'd0, 8'd255, 1'b0, 1'b0);
      send_pixel(32'h0000_0000, 1'b1);
      // flat image: nothing differs anywhere
      configure(9'd3, 9'd3, 8'd1, 8'd1, 1'b1, 1'b1);
      for (int i = 0; i < 9; i++) send_pixel(32'h1234_5678, i == 8);
      // one row with an edge left of the start and one right of it
      configure(9'd4, 9'd1, 8'd2, 8'd0, 1'b1, 1'b1);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);

      // random images: mostly whole banded images, some short or overlong loads
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items == 0 || $urandom_range(0, 1) == 0) begin
            w = draw_size();
            h = draw_size();
            // keep every search inside the prefilled part of the store
            if (fit_size(int'(w), MAX_WIDTH) * fit_size(int'(h), MAX_HEIGHT) > AREA_CAP)
               h = 9'($urandom_range(1, 4));
            configure(w, h,
                      pick_start(fit_size(int'(w), MAX_WIDTH)),
                      pick_start(fit_size(int'(h), MAX_HEIGHT)),
                      $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
         end
         plan_pattern();
         area = cols * rows;
         if (area > 256) begin
            // large geometry: short load over the older store contents
            count = $urandom_range(1, 48);
         end else begin
            case ($urandom_range(0, 15))
               0: count = $urandom_range(1, area);
               1: count = area + $urandom_range(1, 20);
               default: count = area;
            endcase
         end
         send_image(count);
         random_items += count;
      end

      // drain: wait for the last results, then a quiet stretch for strays
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expect_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // hard stop, about ten times the slowest legal run
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
